// ----- rtl/assert_macros.svh -----
// Assertion macros for the crossfade smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a given clock, disabled while the given active-low reset is low.
`define TCS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: check failed");

// The same check on the house clock and reset.
`define TCS_ASSERT_CLK(name, prop) \
  `TCS_ASSERT(name, clk_i, rst_ni, prop)

`endif

// ----- rtl/tcs_pkg.sv -----
// Shared types and constants of the trilinear crossfade smoother.
`default_nettype none

package tcs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FILTER_BITS_DEF = 24;

  localparam int unsigned CV_W      = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned POS_W     = 17;   // Q0.16 plus the exact value 1.0
  localparam int unsigned STEP_W    = 3;

  localparam logic [POS_W-1:0] POS_ONE = 17'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIPOLAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd4;

  // Position steps
  localparam logic [STEP_W-1:0] AXIS_X = 3'd0;
  localparam logic [STEP_W-1:0] AXIS_Y = 3'd1;
  localparam logic [STEP_W-1:0] AXIS_Z = 3'd2;

  // Blend steps: edges along x, faces along inverted y, then the cube along z
  localparam logic [STEP_W-1:0] BL_E0_Z0 = 3'd0;
  localparam logic [STEP_W-1:0] BL_E1_Z0 = 3'd1;
  localparam logic [STEP_W-1:0] BL_F_Z0  = 3'd2;
  localparam logic [STEP_W-1:0] BL_E0_Z1 = 3'd3;
  localparam logic [STEP_W-1:0] BL_E1_Z1 = 3'd4;
  localparam logic [STEP_W-1:0] BL_F_Z1  = 3'd5;
  localparam logic [STEP_W-1:0] BL_CUBE  = 3'd6;

  // Filter steps
  localparam logic [STEP_W-1:0] POLE_FIRST  = 3'd0;
  localparam logic [STEP_W-1:0] POLE_SECOND = 3'd1;

  localparam logic [STEP_W-1:0] POS_LAST   = AXIS_Z;
  localparam logic [STEP_W-1:0] BLEND_LAST = BL_CUBE;
  localparam logic [STEP_W-1:0] POLE_LAST  = POLE_SECOND;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_POS,
    OP_BLEND,
    OP_POLE
  } dp_op_e;

  typedef struct packed {
    logic              load;      // capture an input transaction
    dp_op_e            op;
    logic              wb;        // 0: multiply into the product register, 1: write back
    logic [STEP_W-1:0] step;
    logic              out_load;  // move the filtered sample into the output register
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tcs_ctrl.sv -----
// Sequencer of the crossfade smoother: steps the shared multiplier and owns both handshakes.
`default_nettype none

`include "assert_macros.svh"

module tcs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tcs_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_BLEND,
    ST_POLE,
    ST_FINISH
  } state_e;

  state_e                          state_q;
  logic [tcs_pkg::STEP_W-1:0]      step_q;
  logic                            phase_q;
  logic                            out_valid_q;
  logic [tcs_pkg::STEP_W-1:0]      last_step;

  always_comb begin
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.op       = tcs_pkg::OP_NONE;
    cmd_o.wb       = phase_q;
    cmd_o.step     = step_q;
    cmd_o.out_load = 1'b0;
    last_step      = tcs_pkg::POS_LAST;
    case (state_q)
      ST_POS: begin
        cmd_o.op  = tcs_pkg::OP_POS;
        last_step = tcs_pkg::POS_LAST;
      end
      ST_BLEND: begin
        cmd_o.op  = tcs_pkg::OP_BLEND;
        last_step = tcs_pkg::BLEND_LAST;
      end
      ST_POLE: begin
        cmd_o.op  = tcs_pkg::OP_POLE;
        last_step = tcs_pkg::POLE_LAST;
      end
      ST_FINISH: begin
        cmd_o.out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        cmd_o.op = tcs_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_POS;
            step_q  <= '0;
            phase_q <= 1'b0;
          end
        end
        ST_POS, ST_BLEND, ST_POLE: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (step_q == last_step) begin
              step_q <= '0;
              case (state_q)
                ST_POS:   state_q <= ST_BLEND;
                ST_BLEND: state_q <= ST_POLE;
                default:  state_q <= ST_FINISH;
              endcase
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `TCS_ASSERT_CLK(a_load_starts_pos,
      cmd_o.load |=> (state_q == ST_POS && step_q == '0 && !phase_q))
  `TCS_ASSERT_CLK(a_mul_then_wb,
      ((state_q == ST_POS || state_q == ST_BLEND || state_q == ST_POLE) && !phase_q) |=> phase_q)
  `TCS_ASSERT_CLK(a_out_slot_free,
      cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
  `TCS_ASSERT_CLK(a_out_from_finish,
      $rose(out_valid_o) |-> $past(state_q == ST_FINISH))

endmodule

`default_nettype wire

// ----- rtl/tcs_dp.sv -----
// Datapath of the crossfade smoother: operand registers, one shared multiplier, write-back.
`default_nettype none

module tcs_dp #(
  parameter int unsigned SAMPLE_BITS = tcs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FILTER_BITS = tcs_pkg::FILTER_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tcs_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire tcs_pkg::dp_cmd_t                    cmd_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_000_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_100_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_010_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_110_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_001_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_101_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_011_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       corner_111_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0]     cv_x_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0]     cv_y_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0]     cv_z_i,
  output logic signed [SAMPLE_BITS-1:0]            sample_out_o
);

  localparam int unsigned GUARD = FILTER_BITS - SAMPLE_BITS;
  localparam int unsigned MA_W  = FILTER_BITS + 1;
  localparam int unsigned MB_W  = tcs_pkg::POS_W + 1;
  localparam int unsigned P_W   = MA_W + MB_W;
  localparam int unsigned CVP_W = 2 * tcs_pkg::CV_W;
  localparam int unsigned PV_W  = CVP_W + 2;
  localparam int unsigned POS_W = tcs_pkg::POS_W;

  localparam logic signed [P_W-1:0]       RND   = P_W'(32768);
  localparam logic signed [PV_W-1:0]      BIAS  = PV_W'(64'sd536870912);
  localparam logic signed [PV_W-1:0]      PONE  = PV_W'(tcs_pkg::POS_ONE);
  localparam logic signed [FILTER_BITS:0] HALF  =
      (GUARD > 0) ? ((FILTER_BITS + 1)'(1) << ((GUARD > 0) ? GUARD - 1 : 0)) : '0;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Configuration
  logic                              unipolar_q;
  logic signed [tcs_pkg::CFG_W-1:0]  trim_x_q, trim_y_q, trim_z_q;
  logic [tcs_pkg::CFG_W-1:0]         smoothing_q;

  // Operands of the current transaction
  logic signed [SAMPLE_BITS-1:0]     c000_q, c100_q, c010_q, c110_q;
  logic signed [SAMPLE_BITS-1:0]     c001_q, c101_q, c011_q, c111_q;
  logic signed [tcs_pkg::CV_W-1:0]   cv_x_q, cv_y_q, cv_z_q;
  logic [POS_W-1:0]                  pos_x_q, pos_y_q, pos_z_q;
  logic signed [SAMPLE_BITS-1:0]     e0_q, e1_q, f0_q, f1_q, mix_q;
  logic signed [P_W-1:0]             prod_q;
  logic signed [SAMPLE_BITS-1:0]     sample_q;

  // Filter state
  logic signed [FILTER_BITS-1:0]     first_q, second_q;

  // Operand selection
  logic signed [tcs_pkg::CV_W-1:0]   cv_sel, trim_sel;
  logic signed [SAMPLE_BITS-1:0]     bl_a, bl_b;
  logic [POS_W-1:0]                  bl_t;
  logic signed [SAMPLE_BITS:0]       bl_diff;
  logic signed [FILTER_BITS-1:0]     mix_ext, pl_s, pl_u;
  logic signed [FILTER_BITS:0]       pl_diff;
  logic signed [MA_W-1:0]            ma;
  logic signed [MB_W-1:0]            mb;
  logic signed [P_W-1:0]             prod_d;

  // Write-back
  logic signed [P_W-1:0]             prod_rnd;
  logic signed [P_W-17:0]            prod_hi;
  logic signed [SAMPLE_BITS+1:0]     bl_sum;
  logic signed [SAMPLE_BITS-1:0]     bl_new;
  logic signed [FILTER_BITS:0]       pl_sum;
  logic signed [FILTER_BITS-1:0]     pl_new;
  logic signed [CVP_W-1:0]           p_cv;
  logic signed [PV_W-1:0]            pv, pv_sh;
  logic [POS_W-1:0]                  pos_new;
  logic signed [FILTER_BITS:0]       out_sum;
  logic signed [SAMPLE_BITS:0]       out_r;
  logic signed [SAMPLE_BITS-1:0]     out_sat;

  always_comb begin
    case (cmd_i.step)
      tcs_pkg::AXIS_X: begin
        cv_sel   = cv_x_q;
        trim_sel = trim_x_q;
      end
      tcs_pkg::AXIS_Y: begin
        cv_sel   = cv_y_q;
        trim_sel = trim_y_q;
      end
      default: begin
        cv_sel   = cv_z_q;
        trim_sel = trim_z_q;
      end
    endcase

    // y is inverted: the y1 edge is the first operand of each face blend
    case (cmd_i.step)
      tcs_pkg::BL_E0_Z0: begin
        bl_a = c010_q; bl_b = c110_q; bl_t = pos_x_q;
      end
      tcs_pkg::BL_E1_Z0: begin
        bl_a = c000_q; bl_b = c100_q; bl_t = pos_x_q;
      end
      tcs_pkg::BL_F_Z0: begin
        bl_a = e0_q;   bl_b = e1_q;   bl_t = pos_y_q;
      end
      tcs_pkg::BL_E0_Z1: begin
        bl_a = c011_q; bl_b = c111_q; bl_t = pos_x_q;
      end
      tcs_pkg::BL_E1_Z1: begin
        bl_a = c001_q; bl_b = c101_q; bl_t = pos_x_q;
      end
      tcs_pkg::BL_F_Z1: begin
        bl_a = e0_q;   bl_b = e1_q;   bl_t = pos_y_q;
      end
      default: begin
        bl_a = f0_q;   bl_b = f1_q;   bl_t = pos_z_q;
      end
    endcase
    bl_diff = (SAMPLE_BITS + 1)'(bl_b) - (SAMPLE_BITS + 1)'(bl_a);

    mix_ext = FILTER_BITS'(mix_q);
    if (cmd_i.step == tcs_pkg::POLE_FIRST) begin
      pl_s = first_q;
      pl_u = mix_ext <<< GUARD;
    end else begin
      pl_s = second_q;
      pl_u = first_q;
    end
    pl_diff = MA_W'(pl_s) - MA_W'(pl_u);

    case (cmd_i.op)
      tcs_pkg::OP_POS: begin
        ma = MA_W'(cv_sel);
        mb = MB_W'(trim_sel);
      end
      tcs_pkg::OP_BLEND: begin
        ma = MA_W'(bl_diff);
        mb = signed'({1'b0, bl_t});
      end
      tcs_pkg::OP_POLE: begin
        ma = pl_diff;
        mb = signed'({2'b00, smoothing_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_d = P_W'(ma) * P_W'(mb);

    // floor((prod + 1/2) / 2^16) then add back the start point
    prod_rnd = prod_q + RND;
    prod_hi  = prod_rnd[P_W-1:16];
    bl_sum   = (SAMPLE_BITS + 2)'(bl_a) + (SAMPLE_BITS + 2)'(prod_hi);
    bl_new   = bl_sum[SAMPLE_BITS-1:0];
    pl_sum   = MA_W'(pl_u) + MA_W'(prod_hi);
    pl_new   = pl_sum[FILTER_BITS-1:0];

    // Position map and clamp
    p_cv = prod_q[CVP_W-1:0];
    if (unipolar_q) begin
      pv    = PV_W'(p_cv);
      pv_sh = pv >>> 13;
    end else begin
      pv    = PV_W'(p_cv) + BIAS;
      pv_sh = pv >>> 14;
    end
    if (pv[PV_W-1] || (pv == '0)) begin
      pos_new = '0;
    end else if (pv_sh >= PONE) begin
      pos_new = tcs_pkg::POS_ONE;
    end else begin
      pos_new = pv_sh[POS_W-1:0];
    end

    // Output rounding and saturation
    out_sum = (FILTER_BITS + 1)'(second_q) + HALF;
    out_r   = out_sum[FILTER_BITS:GUARD];
    if (out_r[SAMPLE_BITS] != out_r[SAMPLE_BITS-1]) begin
      out_sat = out_r[SAMPLE_BITS] ? S_MIN : S_MAX;
    end else begin
      out_sat = out_r[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unipolar_q  <= 1'b0;
      trim_x_q    <= 16'sd16384;
      trim_y_q    <= 16'sd16384;
      trim_z_q    <= 16'sd16384;
      smoothing_q <= '0;
      first_q     <= '0;
      second_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcs_pkg::REG_UNIPOLAR:  unipolar_q  <= cfg_data_i[0];
          tcs_pkg::REG_TRIM_X:    trim_x_q    <= cfg_data_i;
          tcs_pkg::REG_TRIM_Y:    trim_y_q    <= cfg_data_i;
          tcs_pkg::REG_TRIM_Z:    trim_z_q    <= cfg_data_i;
          tcs_pkg::REG_SMOOTHING: smoothing_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == tcs_pkg::OP_POLE && cmd_i.wb) begin
        if (cmd_i.step == tcs_pkg::POLE_FIRST) begin
          first_q <= pl_new;
        end else begin
          second_q <= pl_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c000_q <= corner_000_i;
      c100_q <= corner_100_i;
      c010_q <= corner_010_i;
      c110_q <= corner_110_i;
      c001_q <= corner_001_i;
      c101_q <= corner_101_i;
      c011_q <= corner_011_i;
      c111_q <= corner_111_i;
      cv_x_q <= cv_x_i;
      cv_y_q <= cv_y_i;
      cv_z_q <= cv_z_i;
    end
    if (!cmd_i.wb) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == tcs_pkg::OP_POS && cmd_i.wb) begin
      case (cmd_i.step)
        tcs_pkg::AXIS_X: pos_x_q <= pos_new;
        tcs_pkg::AXIS_Y: pos_y_q <= pos_new;
        default:         pos_z_q <= pos_new;
      endcase
    end
    if (cmd_i.op == tcs_pkg::OP_BLEND && cmd_i.wb) begin
      case (cmd_i.step)
        tcs_pkg::BL_E0_Z0, tcs_pkg::BL_E0_Z1: e0_q  <= bl_new;
        tcs_pkg::BL_E1_Z0, tcs_pkg::BL_E1_Z1: e1_q  <= bl_new;
        tcs_pkg::BL_F_Z0:                     f0_q  <= bl_new;
        tcs_pkg::BL_F_Z1:                     f1_q  <= bl_new;
        default:                              mix_q <= bl_new;
      endcase
    end
    if (cmd_i.out_load) begin
      sample_q <= out_sat;
    end
  end

  assign sample_out_o = sample_q;

endmodule

`default_nettype wire

// ----- rtl/trilinear_crossfade_smoother_top.sv -----
// Top level of the trilinear crossfade smoother: sequencer plus shared-multiplier datapath.
//
//   channel   handshake                 payload
//   --------  ------------------------  ------------------------------------------
//   in        in_valid_i / in_stall_o   corner_000_i .. corner_111_i, cv_x/y/z_i
//   out       out_valid_o / out_stall_i sample_out_o
//   cfg       cfg_we_i                  cfg_idx_i, cfg_data_i (no read-back)
//
// Throughput: the single multiplier serialises each transaction into twelve products
//   (three positions, seven blends, two filter poles), each with a product phase and a
//   write-back phase; in_stall_o stays high from acceptance until the output register
//   is loaded, so the next input is taken only once the result has been handed over.
// Reset: rst_ni clears the sequencer, both filter stages and the registers to their
//   defaults (bipolar, unity trims, no smoothing).
// Stalls: the output register holds a finished sample while out_stall_i is high; the
//   next transaction is still accepted and computed, then waits for the slot to free.
`default_nettype none

module trilinear_crossfade_smoother_top #(
  parameter int unsigned SAMPLE_BITS = tcs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FILTER_BITS = tcs_pkg::FILTER_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tcs_pkg::CFG_W-1:0]       cfg_data_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_000_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_100_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_010_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_110_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_001_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_101_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_011_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   corner_111_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0] cv_x_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0] cv_y_i,
  input  wire logic signed [tcs_pkg::CV_W-1:0] cv_z_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o
);

  // Command from the sequencer: capture, multiply/write-back step, output load
  tcs_pkg::dp_cmd_t cmd;

  // Sequencer: accepts a transaction in idle, walks positions, blends, filter poles
  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: holds the registers, operands, filter state and output sample
  tcs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FILTER_BITS (FILTER_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .corner_000_i (corner_000_i),
    .corner_100_i (corner_100_i),
    .corner_010_i (corner_010_i),
    .corner_110_i (corner_110_i),
    .corner_001_i (corner_001_i),
    .corner_101_i (corner_101_i),
    .corner_011_i (corner_011_i),
    .corner_111_i (corner_111_i),
    .cv_x_i       (cv_x_i),
    .cv_y_i       (cv_y_i),
    .cv_z_i       (cv_z_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

// ----- dv/trilinear_crossfade_smoother_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the trilinear crossfade smoother: random and directed cubes.

typedef logic signed [tcs_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
typedef logic signed [tcs_pkg::CV_W-1:0]            cv_t;

// One input transaction: corners ordered 000, 100, 010, 110, 001, 101, 011, 111 (x y z)
typedef struct {
  sample_t corner [8];
  cv_t     cv [3];
} cube_sample_t;

typedef struct {
  logic                      unipolar;
  logic [tcs_pkg::CFG_W-1:0] trim [3];
  logic [tcs_pkg::CFG_W-1:0] smoothing;
} knob_set_t;

class crossfade_scoreboard;
  localparam int     SW    = tcs_pkg::SAMPLE_BITS_DEF;
  localparam int     GUARD = tcs_pkg::FILTER_BITS_DEF - tcs_pkg::SAMPLE_BITS_DEF;
  localparam longint UNIT  = 65536;
  localparam int     MAX_PRINTED = 40;

  bit      unipolar;
  longint  trim [3];
  longint  coef;
  longint  stage1;
  longint  stage2;
  sample_t expected_samples [$];
  int      accepted;
  int      checked;
  int      mismatches;

  function new();
    unipolar   = 1'b0;
    trim       = '{16384, 16384, 16384};
    coef       = 0;
    stage1     = 0;
    stage2     = 0;
    accepted   = 0;
    checked    = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [tcs_pkg::CFG_IDX_W-1:0] idx, logic [tcs_pkg::CFG_W-1:0] data);
    case (idx)
      tcs_pkg::REG_UNIPOLAR:  unipolar = data[0];
      tcs_pkg::REG_TRIM_X:    trim[0]  = longint'($signed(data));
      tcs_pkg::REG_TRIM_Y:    trim[1]  = longint'($signed(data));
      tcs_pkg::REG_TRIM_Z:    trim[2]  = longint'($signed(data));
      tcs_pkg::REG_SMOOTHING: coef     = longint'(data);
      default: ;
    endcase
  endfunction

  // Scale the cv by its trim, map it onto 0..1 (Q0.16) and clamp
  function longint axis_position(longint cv, longint gain);
    longint p;
    longint pos;
    p = cv * gain;
    if (unipolar) begin
      pos = (p <= 0) ? 0 : (p >>> 13);
    end else begin
      p   = p + (longint'(1) <<< 29);
      pos = (p <= 0) ? 0 : (p >>> 14);
    end
    return (pos > UNIT) ? UNIT : pos;
  endfunction

  function longint lerp(longint a, longint b, longint t);
    return (a * (UNIT - t) + b * t + 32768) >>> 16;
  endfunction

  // y runs inverted: y = 0 picks the y1 edge
  function longint face(longint c00, longint c10, longint c01, longint c11,
                        longint x, longint y);
    return lerp(lerp(c01, c11, x), lerp(c00, c10, x), y);
  endfunction

  function longint settle(longint s, longint u);
    return (s * coef + u * (UNIT - coef) + 32768) >>> 16;
  endfunction

  function void note_cube(cube_sample_t s);
    longint c [8];
    longint x, y, z, mixed, r;
    longint hi, lo;
    foreach (c[i]) c[i] = longint'(s.corner[i]);
    x = axis_position(longint'(s.cv[0]), trim[0]);
    y = axis_position(longint'(s.cv[1]), trim[1]);
    z = axis_position(longint'(s.cv[2]), trim[2]);
    mixed = lerp(face(c[0], c[1], c[2], c[3], x, y), face(c[4], c[5], c[6], c[7], x, y), z);
    stage1 = settle(stage1, mixed <<< GUARD);
    stage2 = settle(stage2, stage1);
    if (GUARD > 0) begin
      r = (stage2 + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
    end else begin
      r = stage2;
    end
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -(longint'(1) <<< (SW - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    expected_samples.push_back(sample_t'(r));
    accepted++;
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task check_sample(sample_t got);
    sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("sample_out %0d arrived with nothing pending", got));
    end else begin
      want = expected_samples.pop_front();
      checked++;
      if (got !== want)
        report_mismatch($sformatf("sample %0d: sample_out got %0d, want %0d", checked, got, want));
    end
  endtask

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module trilinear_crossfade_smoother_top_tb;
  import tcs_pkg::*;

  localparam int SW              = SAMPLE_BITS_DEF;
  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 10;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int PRESSURE_PHASE  = 7;
  localparam int HOLD_CYCLES     = 600;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 400000;

  localparam sample_t SAMPLE_TOP    = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SW-1){1'b0}}};
  localparam cv_t     CV_TOP        = {1'b0, {(CV_W-1){1'b1}}};
  localparam cv_t     CV_BOTTOM     = {1'b1, {(CV_W-1){1'b0}}};

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  sample_t              corner_000_i = '0;
  sample_t              corner_100_i = '0;
  sample_t              corner_010_i = '0;
  sample_t              corner_110_i = '0;
  sample_t              corner_001_i = '0;
  sample_t              corner_101_i = '0;
  sample_t              corner_011_i = '0;
  sample_t              corner_111_i = '0;
  cv_t                  cv_x_i       = '0;
  cv_t                  cv_y_i       = '0;
  cv_t                  cv_z_i       = '0;
  logic                 out_stall_i  = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  sample_t              sample_out_o;

  // Idle odds in percent, set per phase by the main sequence
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Bump to ask the receiver for one long hold-off
  int hold_req       = 0;

  crossfade_scoreboard sb = new();

  trilinear_crossfade_smoother_top #(
    .SAMPLE_BITS (SAMPLE_BITS_DEF),
    .FILTER_BITS (FILTER_BITS_DEF)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .corner_000_i (corner_000_i),
    .corner_100_i (corner_100_i),
    .corner_010_i (corner_010_i),
    .corner_110_i (corner_110_i),
    .corner_001_i (corner_001_i),
    .corner_101_i (corner_101_i),
    .corner_011_i (corner_011_i),
    .corner_111_i (corner_111_i),
    .cv_x_i       (cv_x_i),
    .cv_y_i       (cv_y_i),
    .cv_z_i       (cv_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: end the run if the handshakes never finish
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("trilinear_crossfade_smoother_top test failed");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Check every output transaction against the oldest predicted sample
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_sample(sample_out_o);
  end

  // Offer one cube after a random gap; keep valid high on return so back-to-back
  // transactions never lower and raise it within one step
  task automatic offer_cube(input cube_sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    corner_000_i <= s.corner[0];
    corner_100_i <= s.corner[1];
    corner_010_i <= s.corner[2];
    corner_110_i <= s.corner[3];
    corner_001_i <= s.corner[4];
    corner_101_i <= s.corner[5];
    corner_011_i <= s.corner[6];
    corner_111_i <= s.corner[7];
    cv_x_i       <= s.cv[0];
    cv_y_i       <= s.cv[1];
    cv_z_i       <= s.cv[2];
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_cube(s);
  endtask

  // Drop valid and wait for every predicted sample to come out
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Hold the write strobe high; the caller drops it after the last write
  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_knobs(input knob_set_t k);
    // Upper bits of the mode write are junk and must be masked off
    put_register(REG_UNIPOLAR, {(CFG_W-1)'($urandom()), k.unipolar});
    put_register(REG_TRIM_X, k.trim[0]);
    put_register(REG_TRIM_Y, k.trim[1]);
    put_register(REG_TRIM_Z, k.trim[2]);
    put_register(REG_SMOOTHING, k.smoothing);
    // An index past the last register must leave everything alone
    put_register(REG_SMOOTHING + CFG_IDX_W'($urandom_range(1, 3)), CFG_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] random_trim();
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom());
    return CFG_W'($urandom_range(0, 32768) - 16384);
  endfunction

  // Hit the extremes first, then wander
  function automatic knob_set_t phase_knobs(input int ph);
    knob_set_t k;
    case (ph)
      1: k = '{1'b1, '{16'sh7FFF, 16'sh8000, 16'sh0000}, 16'hFFFF};
      2: k = '{1'b0, '{16'sh8000, 16'sh7FFF, -16'sd16384}, 16'h0000};
      3: k = '{1'b1, '{-16'sd16384, 16'sd16384, 16'sh7FFF}, 16'h8000};
      default: begin
        k.unipolar = 1'($urandom());
        foreach (k.trim[i]) k.trim[i] = random_trim();
        case ($urandom_range(0, 3))
          0:       k.smoothing = '0;
          1:       k.smoothing = CFG_W'(16'hFFFF - $urandom_range(0, 255));
          default: k.smoothing = CFG_W'($urandom());
        endcase
      end
    endcase
    return k;
  endfunction

  function automatic cv_t random_cv();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 2))
          0:       return CV_TOP;
          1:       return CV_BOTTOM;
          default: return '0;
        endcase
      end
      1:       return CV_W'($urandom_range(0, 2048) - 1024);
      default: return CV_W'($urandom());
    endcase
  endfunction

  function automatic cube_sample_t random_cube();
    cube_sample_t s;
    int style;
    style = $urandom_range(0, 7);
    foreach (s.corner[i]) begin
      case (style)
        0:       s.corner[i] = $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
        1:       s.corner[i] = SW'($urandom_range(0, 512) - 256);
        default: s.corner[i] = SW'($urandom());
      endcase
    end
    foreach (s.cv[i]) s.cv[i] = random_cv();
    return s;
  endfunction

  // Directed cubes at reset settings: with no smoothing the output is the blend itself
  task automatic run_directed();
    cv_t cv_table [10][3] = '{
      '{16'sd0,     16'sd0,      16'sd0},
      '{CV_TOP,     CV_TOP,      CV_TOP},
      '{CV_BOTTOM,  CV_BOTTOM,   CV_BOTTOM},
      '{CV_TOP,     CV_BOTTOM,   16'sd0},
      '{CV_BOTTOM,  CV_TOP,      16'sd16384},
      '{16'sd16384, -16'sd16384, CV_TOP},
      '{16'sd1,     -16'sd1,     16'sd8192},
      '{-16'sd8192, 16'sd12345,  -16'sd1},
      '{16'sd0,     CV_TOP,      CV_BOTTOM},
      '{-16'sd2,    16'sd2,      16'sd3}
    };
    cube_sample_t s;
    // Raise one corner to the top, sink the rest, and steer every axis onto it;
    // catches a swapped corner or a y axis that is not inverted
    for (int k = 0; k < 8; k++) begin
      foreach (s.corner[i]) s.corner[i] = (i == k) ? SAMPLE_TOP : SAMPLE_BOTTOM;
      s.cv[0] = k[0] ? CV_TOP : CV_BOTTOM;
      s.cv[1] = k[1] ? CV_BOTTOM : CV_TOP;
      s.cv[2] = k[2] ? CV_TOP : CV_BOTTOM;
      offer_cube(s);
    end
    // Sweep control voltages over a spread cube, plus flat full-scale cubes
    for (int t = 0; t < 10; t++) begin
      foreach (s.corner[i]) begin
        if (t == 1) s.corner[i] = SAMPLE_TOP;
        else if (t == 2) s.corner[i] = SAMPLE_BOTTOM;
        else s.corner[i] = SW'(i * 9000 - 32768);
      end
      foreach (s.cv[i]) s.cv[i] = cv_table[t][i];
      offer_cube(s);
    end
  endtask

  initial begin : main
    knob_set_t    knobs;
    cube_sample_t s;

    // Hold reset, then release on a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Reprogram only with the pipeline empty; phase 0 runs on reset values
      if (ph > 0) begin
        drain_pipeline();
        knobs = phase_knobs(ph);
        apply_knobs(knobs);
      end
      if (ph < NUM_PHASES / 3) begin
        send_idle_pct  = 37;
        recv_stall_pct = 48;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        send_idle_pct  = 48;
        recv_stall_pct = 37;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (ph == 0) run_directed();
      // Starve the output while input keeps coming so the block backs up
      if (ph == PRESSURE_PHASE) hold_req++;
      repeat (ITEMS_PER_PHASE) begin
        s = random_cube();
        offer_cube(s);
      end
    end

    drain_pipeline();
    // Watch a while longer for stray output transactions
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d of %0d cubes over %0d register settings: both cv maps,",
             sb.checked, sb.accepted, NUM_PHASES);
    $display("trims to full scale and negative, smoothing 0..65535, one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("trilinear_crossfade_smoother_top test passed");
    end else begin
      $display("trilinear_crossfade_smoother_top test failed");
    end
    $finish;
  end

endmodule
